@@ hw/rtl/key_event_to_hid_report_defines.svh @@
// Assertion macros used by the checker file of the key event to HID report block
`ifndef KEY_EVENT_TO_HID_REPORT_DEFINES_SVH
`define KEY_EVENT_TO_HID_REPORT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define KEHID_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kehid: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define KEHID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kehid: next-cycle check failed");

`endif

@@ hw/rtl/kehid_pkg.sv @@
// Types, constants and the key code to usage table of the HID report builder
package kehid_pkg;

	// Slot chain and table sizes
	localparam int SLOT_COUNT  = 6;
	localparam int MAP_ENTRIES = 101;
	localparam int TABLE_SIZE  = 101;
	localparam int OUT_FIELDS  = 6;
	localparam int USAGE_W     = 8;
	localparam int TABLE_IDX_W = $clog2(TABLE_SIZE);

	// Event type and key action codes
	localparam logic [15:0] EV_SYNC     = 16'd0;
	localparam logic [15:0] EV_KEY      = 16'd1;
	localparam logic [31:0] VAL_RELEASE = 32'd0;
	localparam logic [31:0] VAL_PRESS   = 32'd1;

	typedef logic [USAGE_W-1:0] usage_t;

	// Input event
	typedef struct packed {
		logic [15:0] event_type;
		logic [15:0] key_code;
		logic [31:0] event_value;
	} in_t;

	// Emitted report
	typedef struct packed {
		usage_t slot0_usage;
		usage_t slot1_usage;
		usage_t slot2_usage;
		usage_t slot3_usage;
		usage_t slot4_usage;
		usage_t slot5_usage;
	} out_t;

	// Command broadcast to every slot cell
	typedef struct packed {
		logic   press;
		logic   release_key;
		usage_t usage;
	} cmd_t;

	// Status passed from one cell to the next
	typedef struct packed {
		logic done;   // press already resolved further up the chain
		logic hit;    // released usage found further up the chain
	} link_t;

	localparam usage_t USAGE_TABLE [TABLE_SIZE] = '{
		8'd0,   8'd41,  8'd30,  8'd31,  8'd32,  8'd33,  8'd34,  8'd35,  8'd36,  8'd37,
		8'd38,  8'd39,  8'd45,  8'd46,  8'd42,  8'd43,  8'd20,  8'd26,  8'd8,   8'd21,
		8'd23,  8'd28,  8'd24,  8'd12,  8'd18,  8'd19,  8'd47,  8'd48,  8'd40,  8'd224,
		8'd4,   8'd22,  8'd7,   8'd9,   8'd10,  8'd11,  8'd13,  8'd14,  8'd15,  8'd51,
		8'd52,  8'd53,  8'd225, 8'd49,  8'd29,  8'd27,  8'd6,   8'd25,  8'd5,   8'd17,
		8'd16,  8'd54,  8'd55,  8'd56,  8'd229, 8'd85,  8'd226, 8'd44,  8'd57,  8'd58,
		8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd83,
		8'd71,  8'd95,  8'd96,  8'd97,  8'd86,  8'd92,  8'd93,  8'd94,  8'd87,  8'd89,
		8'd90,  8'd91,  8'd98,  8'd99,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd228, 8'd0,   8'd0,
		8'd230
	};

	// Map a key code to its usage; 0 for ignored or unmapped codes
	function automatic usage_t lookup_usage(input logic [15:0] code);
		usage_t u;
		u = '0;
		if (code != 16'd0 && code < 16'(MAP_ENTRIES) && code < 16'(TABLE_SIZE)) begin
			u = USAGE_TABLE[code[TABLE_IDX_W-1:0]];
		end
		return u;
	endfunction

endpackage

@@ hw/rtl/key_event_to_hid_report.sv @@
// Key event to HID boot keyboard report builder, top level
// One event is taken per clock while in_ready is high: a chain of slot cells
// resolves a press or release, each cell comparing its usage to the event and
// passing done/hit status to the next, and a released slot pulling its right
// neighbor's value. A sync event with report_enable set yields one report of
// the six slots. Reports sit in a two-entry buffer (output register plus skid
// register), so in_ready drops only while both entries hold reports that the
// consumer has not taken; otherwise in_ready stays high. cfg_ready is always
// high and a configuration write takes effect on the next cycle.
module key_event_to_hid_report (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  kehid_pkg::in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output kehid_pkg::out_t out_data
);

	logic              report_enable_q;
	logic              in_fire;
	kehid_pkg::usage_t usage;
	kehid_pkg::cmd_t   cmd;
	logic              emit;
	kehid_pkg::out_t   report;
	kehid_pkg::usage_t slot_val [kehid_pkg::SLOT_COUNT];
	kehid_pkg::usage_t slot_pad [kehid_pkg::OUT_FIELDS];
	kehid_pkg::link_t  link [kehid_pkg::SLOT_COUNT+1];

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			report_enable_q <= cfg_data;
		end
	end

	// Event decode
	assign in_fire = in_valid & in_ready;
	assign usage   = kehid_pkg::lookup_usage(in_data.key_code);

	always_comb begin
		cmd.usage       = usage;
		cmd.press       = 1'b0;
		cmd.release_key = 1'b0;
		if (in_fire && in_data.event_type == kehid_pkg::EV_KEY && usage != '0) begin
			cmd.press       = (in_data.event_value == kehid_pkg::VAL_PRESS);
			cmd.release_key = (in_data.event_value == kehid_pkg::VAL_RELEASE);
		end
	end

	assign emit = in_fire & report_enable_q & (in_data.event_type == kehid_pkg::EV_SYNC);

	// Slot cell chain
	assign link[0] = '0;

	for (genvar i = 0; i < kehid_pkg::SLOT_COUNT; i++) begin : g_cell
		kehid_pkg::usage_t next_slot;
		if (i + 1 < kehid_pkg::SLOT_COUNT) begin : g_mid
			assign next_slot = slot_val[i+1];
		end else begin : g_last
			assign next_slot = '0;
		end

		kehid_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.link_in   (link[i]),
			.next_slot (next_slot),
			.link_out  (link[i+1]),
			.slot      (slot_val[i])
		);
	end

	// Report assembly; fields past the slot count read zero
	for (genvar j = 0; j < kehid_pkg::OUT_FIELDS; j++) begin : g_pad
		if (j < kehid_pkg::SLOT_COUNT) begin : g_slot
			assign slot_pad[j] = slot_val[j];
		end else begin : g_zero
			assign slot_pad[j] = '0;
		end
	end

	assign report.slot0_usage = slot_pad[0];
	assign report.slot1_usage = slot_pad[1];
	assign report.slot2_usage = slot_pad[2];
	assign report.slot3_usage = slot_pad[3];
	assign report.slot4_usage = slot_pad[4];
	assign report.slot5_usage = slot_pad[5];

	// Output buffering
	kehid_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (emit),
		.push_data  (report),
		.push_ready (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

@@ hw/rtl/kehid_cell.sv @@
// One usage slot of the chain: insert on press, shift down on release
module kehid_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kehid_pkg::cmd_t        cmd,
	input  kehid_pkg::link_t       link_in,
	input  kehid_pkg::usage_t      next_slot,
	output kehid_pkg::link_t       link_out,
	output kehid_pkg::usage_t      slot
);

	kehid_pkg::usage_t slot_q;
	logic              match;
	logic              free;
	logic              do_insert;
	logic              do_shift;

	// Compare against the broadcast usage
	assign match = (slot_q == cmd.usage);
	assign free  = (slot_q == '0);

	// Press stops at the first equal or free slot; release marks everything from the hit on
	assign link_out.done = link_in.done | (cmd.press & (match | free));
	assign link_out.hit  = link_in.hit | (cmd.release_key & match);

	assign do_insert = cmd.press & ~link_in.done & free & ~match;
	assign do_shift  = cmd.release_key & link_out.hit;

	// Slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (do_insert) begin
			slot_q <= cmd.usage;
		end else if (do_shift) begin
			slot_q <= next_slot;
		end
	end

	assign slot = slot_q;

endmodule

@@ hw/rtl/kehid_out_buf.sv @@
// Two-entry report buffer: output register plus skid register
module kehid_out_buf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kehid_pkg::out_t push_data,
	output logic            push_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output kehid_pkg::out_t out_data
);

	logic            out_valid_q;
	kehid_pkg::out_t out_data_q;
	logic            skid_valid_q;
	kehid_pkg::out_t skid_data_q;
	logic            out_free;

	assign out_free   = ~out_valid_q | out_ready;
	assign push_ready = ~skid_valid_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ hw/rtl/kehid_checker.sv @@
// Port-level checks of the HID report builder, bound to the top level
`include "key_event_to_hid_report_defines.svh"

module kehid_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input kehid_pkg::out_t out_data
);

	logic packed_ok;

	// Occupied slots are packed from slot 0
	assign packed_ok =
		(out_data.slot0_usage != '0 || out_data.slot1_usage == '0) &&
		(out_data.slot1_usage != '0 || out_data.slot2_usage == '0) &&
		(out_data.slot2_usage != '0 || out_data.slot3_usage == '0) &&
		(out_data.slot3_usage != '0 || out_data.slot4_usage == '0) &&
		(out_data.slot4_usage != '0 || out_data.slot5_usage == '0);

	// Stalled report holds
	`KEHID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// Input backpressure only while a report is pending
	`KEHID_ASSERT_NOW(a_stall_needs_report, !in_ready, out_valid)

	// A new report follows an input transfer
	`KEHID_ASSERT_NOW(a_report_cause, $rose(out_valid), $past(in_valid && in_ready))

	// Reports list held keys without gaps
	`KEHID_ASSERT_NOW(a_slots_packed, out_valid, packed_ok)

endmodule

bind key_event_to_hid_report kehid_checker u_kehid_checker (.*);

@@ bench/key_event_to_hid_report_tb.sv @@
// Testbench for key_event_to_hid_report: event stimulus, slot tracking and report checks
`timescale 1ns / 100ps

// Tracks the held-key slots and the reports that are still due from the block
class hid_report_tracker;
	localparam int SLOTS     = 6;
	localparam int KEY_CODES = 101;

	bit [7:0]         code_map [KEY_CODES];
	bit [7:0]         held [SLOTS];
	bit               reporting;
	kehid_pkg::out_t  due_reports [$];
	int unsigned      bad_count;
	int unsigned      report_num;

	function new();
		code_map = '{
			0, 41, 30, 31, 32, 33, 34, 35, 36, 37,
			38, 39, 45, 46, 42, 43, 20, 26, 8, 21,
			23, 28, 24, 12, 18, 19, 47, 48, 40, 224,
			4, 22, 7, 9, 10, 11, 13, 14, 15, 51,
			52, 53, 225, 49, 29, 27, 6, 25, 5, 17,
			16, 54, 55, 56, 229, 85, 226, 44, 57, 58,
			59, 60, 61, 62, 63, 64, 65, 66, 67, 83,
			71, 95, 96, 97, 86, 92, 93, 94, 87, 89,
			90, 91, 98, 99, 0, 0, 0, 0, 0, 0,
			0, 0, 0, 0, 0, 0, 0, 228, 0, 0,
			230
		};
		foreach (held[i]) held[i] = 8'd0;
		reporting = 1'b0;
		bad_count = 0;
		report_num = 0;
	endfunction

	// Code to usage; 0 for code 0, unmapped entries and codes past the map
	function bit [7:0] usage_of(logic [15:0] code);
		if (code != 16'd0 && code < 16'(KEY_CODES)) begin
			return code_map[code];
		end
		return 8'd0;
	endfunction

	function void set_reporting(bit v);
		reporting = v;
	endfunction

	// Update the slots for one transfer into the block, queue a report on sync
	function void apply_event(kehid_pkg::in_t ev);
		bit [7:0]        u;
		int              pos;
		kehid_pkg::out_t rep;
		if (ev.event_type == kehid_pkg::EV_KEY) begin
			u = usage_of(ev.key_code);
			if (u == 8'd0) return;
			if (ev.event_value == kehid_pkg::VAL_PRESS) begin
				// first free slot, unless already held; dropped when full
				for (int i = 0; i < SLOTS; i++) begin
					if (held[i] == u) break;
					if (held[i] == 8'd0) begin
						held[i] = u;
						break;
					end
				end
			end else if (ev.event_value == kehid_pkg::VAL_RELEASE) begin
				pos = SLOTS;
				for (int i = 0; i < SLOTS; i++) begin
					if (held[i] == u) begin
						pos = i;
						break;
					end
				end
				// close the gap
				if (pos < SLOTS) begin
					for (int i = pos; i < SLOTS - 1; i++) held[i] = held[i + 1];
					held[SLOTS - 1] = 8'd0;
				end
			end
		end else if (ev.event_type == kehid_pkg::EV_SYNC && reporting) begin
			rep = {held[0], held[1], held[2], held[3], held[4], held[5]};
			due_reports.push_back(rep);
		end
	endfunction

	function void note_fault(string msg);
		bad_count++;
		if (bad_count <= 10) $display("[%0t] %s", $time, msg);
	endfunction

	// Compare one report transfer with the oldest due report
	function void check_report(kehid_pkg::out_t got);
		kehid_pkg::out_t want;
		report_num++;
		if (due_reports.size() == 0) begin
			note_fault($sformatf("report %0d: none due, got %h", report_num, got));
			return;
		end
		want = due_reports.pop_front();
		for (int i = 0; i < SLOTS; i++) begin
			if (got[8*(SLOTS-1-i) +: 8] !== want[8*(SLOTS-1-i) +: 8]) begin
				note_fault($sformatf("report %0d slot%0d: expected %0d, got %0d",
					report_num, i, want[8*(SLOTS-1-i) +: 8], got[8*(SLOTS-1-i) +: 8]));
			end
		end
	endfunction

	function void close_out();
		while (due_reports.size() != 0) begin
			note_fault($sformatf("report never arrived: expected %h", due_reports.pop_front()));
		end
	endfunction
endclass

module key_event_to_hid_report_tb;
	logic            clk;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic            cfg_data;
	logic            in_valid;
	logic            in_ready;
	kehid_pkg::in_t  in_data;
	logic            out_valid;
	logic            out_ready;
	kehid_pkg::out_t out_data;

	bit              steady;
	hid_report_tracker tracker = new();

	key_event_to_hid_report u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit, far above the slowest legal run
	initial begin
		#2000000;
		$display("key_event_to_hid_report: mismatch");
		$finish;
	end

	// Watch every transfer at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) tracker.check_report(out_data);
			if (cfg_valid && cfg_ready) tracker.set_reporting(cfg_data);
			if (in_valid && in_ready) tracker.apply_event(in_data);
		end
	end

	// Consumer: ready runs broken by stall bursts, none once steady
	initial begin
		out_ready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 20)) @(negedge clk);
			if (!steady) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	function automatic kehid_pkg::in_t ev_of(logic [15:0] t, logic [15:0] c, logic [31:0] v);
		kehid_pkg::in_t ev;
		ev.event_type  = t;
		ev.key_code    = c;
		ev.event_value = v;
		return ev;
	endfunction

	// One event transfer, sometimes after an idle burst
	task automatic send_event(input kehid_pkg::in_t ev);
		if (!steady && $urandom_range(0, 99) < 15) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= ev;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stop_events();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Stop events and let every due report come out, then idle before going on
	task automatic drain();
		stop_events();
		while (tracker.due_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_enable(input bit v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly presses, releases and syncs, half the keys from a small pool; some noise
	function automatic kehid_pkg::in_t random_event();
		int          pick;
		logic [15:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			if ($urandom_range(0, 1)) begin
				code = 16'($urandom_range(1, 9));
			end else begin
				do code = 16'($urandom_range(1, 100)); while (tracker.usage_of(code) == 8'd0);
			end
			return ev_of(kehid_pkg::EV_KEY, code,
				(pick < 45) ? kehid_pkg::VAL_PRESS : kehid_pkg::VAL_RELEASE);
		end
		if (pick < 88) begin
			if ($urandom_range(0, 1)) return ev_of(kehid_pkg::EV_SYNC, 16'd0, 32'd0);
			return ev_of(kehid_pkg::EV_SYNC, 16'($urandom), $urandom);
		end
		if (pick < 93) begin
			case ($urandom_range(0, 3))
				0: code = 16'd0;
				1: code = 16'($urandom_range(84, 96));
				2: code = 16'($urandom_range(98, 99));
				default: code = 16'($urandom_range(101, 65535));
			endcase
			return ev_of(kehid_pkg::EV_KEY, code, 32'($urandom_range(0, 1)));
		end
		if (pick < 97) begin
			return ev_of(kehid_pkg::EV_KEY, 16'($urandom_range(1, 100)), $urandom);
		end
		return ev_of(16'($urandom), 16'($urandom), $urandom);
	endfunction

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		steady    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: sync while disabled, then fill, overflow, repeats, ignored events
		send_event(ev_of(kehid_pkg::EV_SYNC, 16'd0, 32'd0));
		drain();
		write_enable(1'b1);
		send_event(ev_of(kehid_pkg::EV_SYNC, 16'd0, 32'd0));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd1, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd29, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd42, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd54, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd56, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd97, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd100, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd1, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_SYNC, 16'hFFFF, 32'hFFFF_FFFF));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd29, kehid_pkg::VAL_RELEASE));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd2, kehid_pkg::VAL_RELEASE));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd100, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd0, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd84, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'hFFFF, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd3, 32'd2));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd1, 32'hFFFF_FFFF));
		send_event(ev_of(16'hFFFF, 16'd3, kehid_pkg::VAL_PRESS));
		send_event(ev_of(kehid_pkg::EV_SYNC, 16'd0, 32'd0));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd1, kehid_pkg::VAL_RELEASE));
		send_event(ev_of(kehid_pkg::EV_KEY, 16'd100, kehid_pkg::VAL_RELEASE));
		send_event(ev_of(kehid_pkg::EV_SYNC, 16'd0, 32'd0));

		// Random, reporting on
		repeat (250) send_event(random_event());
		drain();

		// Random, reporting off: slots still move, no reports
		write_enable(1'b0);
		repeat (100) send_event(random_event());
		drain();

		// Random, reporting on; the tail runs without idling
		write_enable(1'b1);
		repeat (150) send_event(random_event());
		steady = 1'b1;
		repeat (100) send_event(random_event());
		stop_events();

		while (tracker.due_reports.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		tracker.close_out();
		if (tracker.bad_count == 0) begin
			$display("key_event_to_hid_report: match");
		end else begin
			$display("key_event_to_hid_report: mismatch");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/kehid_pkg.sv
hw/rtl/kehid_cell.sv
hw/rtl/kehid_out_buf.sv
hw/rtl/key_event_to_hid_report.sv
hw/rtl/kehid_checker.sv
bench/key_event_to_hid_report_tb.sv
